// ===== rtl/utlc_pkg.sv =====
package utlc_pkg;

  localparam logic [11:0] YEAR_MIN = 12'd2024;
  localparam logic [11:0] YEAR_MAX = 12'd2099;

  localparam logic [1:0] TZ_NONE = 2'd0;
  localparam logic [1:0] TZ_UTC  = 2'd1;
  localparam logic [1:0] TZ_CET  = 2'd2;
  localparam logic [1:0] TZ_BAD  = 2'd3;

  localparam logic [1:0] REG_TZ_MODE       = 2'd0;
  localparam logic [1:0] REG_WINDOW_START  = 2'd1;
  localparam logic [1:0] REG_WINDOW_END    = 2'd2;
  localparam logic [1:0] REG_ROLLOVER_HOUR = 2'd3;

  localparam logic [4:0] ROLLOVER_RESET = 5'd4;

  typedef struct packed {
    logic [11:0] utc_year;
    logic [3:0]  utc_month;
    logic [4:0]  utc_day;
    logic [4:0]  utc_hour;
    logic [5:0]  utc_minute;
    logic [5:0]  utc_second;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] local_year;
    logic [3:0]  local_month;
    logic [4:0]  local_day;
    logic [4:0]  local_hour;
    logic [5:0]  local_minute;
    logic [5:0]  local_second;
    logic [2:0]  local_weekday;
    logic        in_window;
    logic [11:0] study_year;
    logic [3:0]  study_month;
    logic [4:0]  study_day;
  } out_t;

  typedef struct packed {
    logic [1:0] tz_mode;
    logic [4:0] window_start;
    logic [4:0] window_end;
    logic [4:0] rollover_hour;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] offset;
  } zone_t;

  // Within 2023 to 2099 every fourth year is a leap year.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Days before the first of the month, modulo 7, in a common year.
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd3;
      4'd4:    o = 3'd6;
      4'd5:    o = 3'd1;
      4'd6:    o = 3'd4;
      4'd7:    o = 3'd6;
      4'd8:    o = 3'd2;
      4'd9:    o = 3'd5;
      4'd10:   o = 3'd0;
      4'd11:   o = 3'd3;
      4'd12:   o = 3'd5;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // Since 8 is 1 modulo 7, octal digits are summed and folded.
  function automatic logic [2:0] mod7(input logic [6:0] x);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] r;
    a = {1'b0, x[2:0]} + {1'b0, x[5:3]} + {3'b0, x[6]};
    b = {1'b0, a[2:0]} + {3'b0, a[3]};
    r = (b >= 4'd7) ? (b - 4'd7) : b;
    return r[2:0];
  endfunction

  // Weekday with Monday as 0; January 1, 2024 was a Monday.
  function automatic logic [2:0] weekday(input logic [11:0] y, input logic [3:0] m,
                                         input logic [4:0] d);
    logic [6:0]  ty;
    logic [6:0]  lp;
    logic [2:0]  jan1;
    logic [6:0]  s;
    ty   = 7'(y - YEAR_MIN);
    lp   = (ty + 7'd3) >> 2;
    jan1 = mod7(ty + lp);
    s    = {4'b0, jan1} + {4'b0, month_offset(m)}
         + {6'b0, (is_leap(y) && (m > 4'd2))} + {2'b0, d} - 7'd1;
    return mod7(s);
  endfunction

endpackage

// ===== rtl/utlc_zone.sv =====
module utlc_zone
  import utlc_pkg::*;
(
  input  in_t        item,
  input  logic [1:0] tz_mode,
  output zone_t      zone
);

  logic       leap;
  logic [4:0] mlen;
  logic       in_ok;
  logic [2:0] wd_last;
  logic [2:0] back;
  logic [4:0] last_sun;
  logic       summer;

  assign leap = is_leap(item.utc_year);
  assign mlen = month_days(item.utc_month, leap);

  assign in_ok = (item.utc_year >= YEAR_MIN) && (item.utc_year <= YEAR_MAX) &&
                 (item.utc_month >= 4'd1) && (item.utc_month <= 4'd12) &&
                 (item.utc_day >= 5'd1) && (item.utc_day <= mlen) &&
                 (item.utc_hour <= 5'd23) && (item.utc_minute <= 6'd59) &&
                 (item.utc_second <= 6'd59);

  // March and October both have 31 days.
  assign wd_last  = weekday(item.utc_year, item.utc_month, 5'd31);
  assign back     = (wd_last == 3'd6) ? 3'd0 : (wd_last + 3'd1);
  assign last_sun = 5'd31 - {2'b0, back};

  always_comb begin
    if (item.utc_month < 4'd3 || item.utc_month > 4'd10) begin
      summer = 1'b0;
    end else if (item.utc_month > 4'd3 && item.utc_month < 4'd10) begin
      summer = 1'b1;
    end else if (item.utc_month == 4'd3) begin
      summer = (item.utc_day != last_sun) ? (item.utc_day > last_sun)
                                          : (item.utc_hour >= 5'd1);
    end else begin
      summer = (item.utc_day != last_sun) ? (item.utc_day < last_sun)
                                          : (item.utc_hour < 5'd1);
    end
  end

  always_comb begin
    case (tz_mode)
      TZ_UTC: begin
        zone.ok     = in_ok;
        zone.offset = 2'd0;
      end
      TZ_CET: begin
        zone.ok     = in_ok;
        zone.offset = summer ? 2'd2 : 2'd1;
      end
      TZ_NONE, TZ_BAD: begin
        zone.ok     = 1'b0;
        zone.offset = 2'd0;
      end
      default: begin
        zone.ok     = 1'b0;
        zone.offset = 2'd0;
      end
    endcase
  end

endmodule

// ===== rtl/utlc_local.sv =====
module utlc_local
  import utlc_pkg::*;
(
  input  in_t   item,
  input  zone_t zone,
  input  cfg_t  cfg,
  output out_t  result
);

  logic [4:0]  h_sum;
  logic        wrap;
  logic [4:0]  lh;
  logic [4:0]  mlen;
  logic [11:0] ly;
  logic [3:0]  lm;
  logic [4:0]  ld;
  logic        ok;
  logic        win;
  logic [11:0] sy;
  logic [3:0]  sm;
  logic [4:0]  sd;

  assign h_sum = item.utc_hour + {3'b0, zone.offset};
  assign wrap  = (h_sum >= 5'd24);
  assign lh    = wrap ? (h_sum - 5'd24) : h_sum;
  assign mlen  = month_days(item.utc_month, is_leap(item.utc_year));

  always_comb begin
    ly = item.utc_year;
    lm = item.utc_month;
    ld = item.utc_day;
    if (wrap) begin
      if (item.utc_day >= mlen) begin
        ld = 5'd1;
        if (item.utc_month >= 4'd12) begin
          lm = 4'd1;
          ly = item.utc_year + 12'd1;
        end else begin
          lm = item.utc_month + 4'd1;
        end
      end else begin
        ld = item.utc_day + 5'd1;
      end
    end
  end

  assign ok = zone.ok && (ly <= YEAR_MAX);

  always_comb begin
    if (cfg.window_start > 5'd23 || cfg.window_end > 5'd23) begin
      win = 1'b0;
    end else if (cfg.window_start == cfg.window_end) begin
      win = 1'b1;
    end else if (cfg.window_start < cfg.window_end) begin
      win = (lh >= cfg.window_start) && (lh < cfg.window_end);
    end else begin
      win = (lh >= cfg.window_start) || (lh < cfg.window_end);
    end
  end

  always_comb begin
    sy = ly;
    sm = lm;
    sd = ld;
    if (lh < cfg.rollover_hour) begin
      if (ld <= 5'd1) begin
        if (lm <= 4'd1) begin
          sm = 4'd12;
          sy = ly - 12'd1;
        end else begin
          sm = lm - 4'd1;
        end
        sd = month_days(sm, is_leap(sy));
      end else begin
        sd = ld - 5'd1;
      end
    end
  end

  always_comb begin
    result = '0;
    if (ok) begin
      result.ok            = 1'b1;
      result.local_year    = ly;
      result.local_month   = lm;
      result.local_day     = ld;
      result.local_hour    = lh;
      result.local_minute  = item.utc_minute;
      result.local_second  = item.utc_second;
      result.local_weekday = weekday(ly, lm, ld);
      result.in_window     = win;
      result.study_year    = sy;
      result.study_month   = sm;
      result.study_day     = sd;
    end
  end

endmodule

// ===== rtl/utc_to_local_calendar_time.sv =====
// Converts a UTC calendar time to local time in UTC or central European
// zone, with weekday, an hour window flag and the study day.
// Input channel: in_valid, in_data, in_stall. An item is taken at a clock
// edge where in_valid is high and in_stall is low.
// Output channel: out_valid, out_data, out_stall. A result is taken at a
// clock edge where out_valid is high and out_stall is low.
// Configuration: cfg_valid, cfg_index, cfg_data, cfg_ready. Ready is always
// high. Only write registers while no item is in flight; not checked here.
// Each item produces exactly one result, passing through the input register
// and then the output register. The conversion is a single combinational
// pass between them, so one item is taken every cycle as long as the
// receiver keeps taking results.
// When the receiver stalls, the output register holds its result and an empty
// input register still takes one more item; after that in_stall rises.
// Reset empties both registers and loads the register defaults: zone none,
// window 0 to 0, rollover hour 4.
module utc_to_local_calendar_time
  import utlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  cfg_t  cfg;
  logic  s1_valid;
  in_t   s1_data;
  logic  advance;
  logic  accept;
  zone_t zone;
  out_t  result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tz_mode       <= TZ_NONE;
      cfg.window_start  <= 5'd0;
      cfg.window_end    <= 5'd0;
      cfg.rollover_hour <= ROLLOVER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TZ_MODE:       cfg.tz_mode       <= cfg_data[1:0];
        REG_WINDOW_START:  cfg.window_start  <= cfg_data;
        REG_WINDOW_END:    cfg.window_end    <= cfg_data;
        REG_ROLLOVER_HOUR: cfg.rollover_hour <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= in_data;
    end
  end

  utlc_zone u_zone (
    .item    (s1_data),
    .tz_mode (cfg.tz_mode),
    .zone    (zone)
  );

  utlc_local u_local (
    .item   (s1_data),
    .zone   (zone),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ===== verif/utc_to_local_calendar_time_checker.sv =====
module utc_to_local_calendar_time_checker
  import utlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_t        in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_t       out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [1:0] zone_mode;
  logic [4:0] win_first;
  logic [4:0] win_last;
  logic [4:0] day_turn_hour;
  out_t       local_time_q[$];

  function automatic bit leap_year(int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int days_in_month(int y, int m);
    int len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) begin
      return 31;
    end
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return len[m - 1];
  endfunction

  function automatic int weekday_from_monday(int y, int m, int d);
    int offs[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    int yy;
    int s;
    yy = (m < 3) ? y - 1 : y;
    s = (yy + yy / 4 - yy / 100 + yy / 400 + offs[m - 1] + d) % 7;
    return (s + 6) % 7;
  endfunction

  function automatic int last_sunday(int y, int m);
    int n;
    n = days_in_month(y, m);
    return n - ((weekday_from_monday(y, m, n) + 1) % 7);
  endfunction

  // Summer time starts and ends at 01:00 UTC on the last Sunday of March and October.
  function automatic bit summer_time_on(int y, int m, int d, int h);
    int t;
    if (m < 3 || m > 10) begin
      return 0;
    end
    if (m > 3 && m < 10) begin
      return 1;
    end
    t = last_sunday(y, m);
    if (m == 3) begin
      return (d != t) ? (d > t) : (h >= 1);
    end
    return (d != t) ? (d < t) : (h < 1);
  endfunction

  function automatic out_t predict_local(in_t it);
    int   y;
    int   mo;
    int   d;
    int   h;
    int   mi;
    int   se;
    int   shift;
    int   sy;
    int   sm;
    int   sd;
    int   ws;
    int   we;
    int   rt;
    bit   win;
    out_t r;
    r  = '0;
    y  = int'(it.utc_year);
    mo = int'(it.utc_month);
    d  = int'(it.utc_day);
    h  = int'(it.utc_hour);
    mi = int'(it.utc_minute);
    se = int'(it.utc_second);
    ws = int'(win_first);
    we = int'(win_last);
    rt = int'(day_turn_hour);
    if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || mo < 1 || mo > 12 || d < 1 ||
        d > days_in_month(y, mo) || h > 23 || mi > 59 || se > 59) begin
      return r;
    end
    if (zone_mode == TZ_UTC) begin
      shift = 0;
    end else if (zone_mode == TZ_CET) begin
      shift = summer_time_on(y, mo, d, h) ? 2 : 1;
    end else begin
      return r;
    end
    h = h + shift;
    if (h >= 24) begin
      h = h - 24;
      d = d + 1;
      if (d > days_in_month(y, mo)) begin
        d  = 1;
        mo = mo + 1;
        if (mo > 12) begin
          mo = 1;
          y  = y + 1;
        end
      end
    end
    if (y > int'(YEAR_MAX)) begin
      return r;
    end
    if (ws > 23 || we > 23) begin
      win = 0;
    end else if (ws == we) begin
      win = 1;
    end else if (ws < we) begin
      win = (h >= ws) && (h < we);
    end else begin
      win = (h >= ws) || (h < we);
    end
    sy = y;
    sm = mo;
    sd = d;
    if (h < rt) begin
      sd = sd - 1;
      if (sd < 1) begin
        sm = sm - 1;
        if (sm < 1) begin
          sm = 12;
          sy = sy - 1;
        end
        sd = days_in_month(sy, sm);
      end
    end
    r.ok            = 1'b1;
    r.local_year    = 12'(y);
    r.local_month   = 4'(mo);
    r.local_day     = 5'(d);
    r.local_hour    = 5'(h);
    r.local_minute  = 6'(mi);
    r.local_second  = 6'(se);
    r.local_weekday = 3'(weekday_from_monday(y, mo, d));
    r.in_window     = win;
    r.study_year    = 12'(sy);
    r.study_month   = 4'(sm);
    r.study_day     = 5'(sd);
    return r;
  endfunction

  task automatic compare_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("Mismatch in %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      zone_mode     = TZ_NONE;
      win_first     = '0;
      win_last      = '0;
      day_turn_hour = ROLLOVER_RESET;
      local_time_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (local_time_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Unexpected result %h with no item outstanding", out_data);
          end
        end else begin
          want = local_time_q.pop_front();
          compare_field("ok", 12'(want.ok), 12'(out_data.ok));
          compare_field("local_year", want.local_year, out_data.local_year);
          compare_field("local_month", 12'(want.local_month), 12'(out_data.local_month));
          compare_field("local_day", 12'(want.local_day), 12'(out_data.local_day));
          compare_field("local_hour", 12'(want.local_hour), 12'(out_data.local_hour));
          compare_field("local_minute", 12'(want.local_minute),
                        12'(out_data.local_minute));
          compare_field("local_second", 12'(want.local_second),
                        12'(out_data.local_second));
          compare_field("local_weekday", 12'(want.local_weekday),
                        12'(out_data.local_weekday));
          compare_field("in_window", 12'(want.in_window), 12'(out_data.in_window));
          compare_field("study_year", want.study_year, out_data.study_year);
          compare_field("study_month", 12'(want.study_month), 12'(out_data.study_month));
          compare_field("study_day", 12'(want.study_day), 12'(out_data.study_day));
        end
      end
      if (in_valid && !in_stall) begin
        local_time_q.push_back(predict_local(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TZ_MODE:       zone_mode = cfg_data[1:0];
          REG_WINDOW_START:  win_first = cfg_data;
          REG_WINDOW_END:    win_last = cfg_data;
          REG_ROLLOVER_HOUR: day_turn_hour = cfg_data;
          default: ;
        endcase
      end
    end
    pending = local_time_q.size();
  end

endmodule

// ===== verif/tb_utc_to_local_calendar_time.sv =====
module tb_utc_to_local_calendar_time;
  import utlc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 60;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  int         fail_count;
  int         pending;

  int send_pct;
  int recv_pct;
  int sent_count;
  int cycle_count = 0;

  logic [1:0] zone_set[8]  = '{TZ_CET, TZ_UTC, TZ_CET, TZ_NONE, TZ_CET, TZ_BAD, TZ_UTC, TZ_CET};
  logic [4:0] start_set[8] = '{5'd22, 5'd8, 5'd5, 5'd0, 5'd31, 5'd3, 5'd23, 5'd0};
  logic [4:0] end_set[8]   = '{5'd6, 5'd17, 5'd5, 5'd23, 5'd3, 5'd24, 5'd0, 5'd23};
  logic [4:0] turn_set[8]  = '{5'd4, 5'd0, 5'd23, 5'd4, 5'd31, 5'd12, 5'd24, 5'd1};

  utc_to_local_calendar_time uut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  utc_to_local_calendar_time_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls at random, and once holds off for a long stretch so the block fills up.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  function automatic int month_length(int y, int m);
    case (m)
      2:            return (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic in_t utc_stamp(int y, int mo, int d, int h, int mi, int se);
    in_t r;
    r.utc_year   = 12'(y);
    r.utc_month  = 4'(mo);
    r.utc_day    = 5'(d);
    r.utc_hour   = 5'(h);
    r.utc_minute = 6'(mi);
    r.utc_second = 6'(se);
    return r;
  endfunction

  // Mostly valid times, biased toward month ends and summer time changes, plus noise.
  function automatic in_t random_item();
    in_t         r;
    logic [63:0] raw;
    int          kind;
    kind = $urandom_range(99);
    r.utc_year   = 12'($urandom_range(2099, 2024));
    r.utc_month  = 4'($urandom_range(12, 1));
    r.utc_day    = 5'($urandom_range(month_length(int'(r.utc_year), int'(r.utc_month)), 1));
    r.utc_hour   = 5'($urandom_range(23, 0));
    r.utc_minute = 6'($urandom_range(59, 0));
    r.utc_second = 6'($urandom_range(59, 0));
    if (kind < 12) begin
      raw = {$urandom, $urandom};
      r = raw[$bits(in_t)-1:0];
    end else if (kind < 20) begin
      case ($urandom_range(5))
        0: r.utc_year = 12'($urandom_range(4095));
        1: r.utc_month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
        2: r.utc_day = $urandom_range(1) ? 5'd0 :
                       5'($urandom_range(31, month_length(int'(r.utc_year),
                                                          int'(r.utc_month)) + 1));
        3: r.utc_hour = 5'($urandom_range(31, 24));
        4: r.utc_minute = 6'($urandom_range(63, 60));
        default: r.utc_second = 6'($urandom_range(63, 60));
      endcase
    end else if (kind < 40) begin
      r.utc_month = $urandom_range(1) ? 4'd3 : 4'd10;
      r.utc_day   = 5'($urandom_range(31, 24));
      r.utc_hour  = $urandom_range(1) ? 5'($urandom_range(2)) : 5'($urandom_range(23, 22));
    end else if (kind < 55) begin
      if ($urandom_range(3) == 0) begin
        r.utc_year  = YEAR_MAX;
        r.utc_month = 4'd12;
      end
      r.utc_day  = 5'(month_length(int'(r.utc_year), int'(r.utc_month)));
      r.utc_hour = 5'($urandom_range(23, 21));
    end
    return r;
  endfunction

  // Every task below starts and ends just after a falling edge.
  task automatic send(in_t d);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_registers(logic [1:0] zone, logic [4:0] first, logic [4:0] last,
                                   logic [4:0] turn);
    logic [2:0] junk;
    junk = 3'($urandom_range(7));
    write_register(REG_TZ_MODE, {junk, zone});
    write_register(REG_WINDOW_START, first);
    write_register(REG_WINDOW_END, last);
    write_register(REG_ROLLOVER_HOUR, turn);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int count;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_TZ_MODE;
    cfg_data   = '0;
    rst        = 1'b1;
    send_pct   = 0;
    recv_pct   = 0;
    sent_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_registers(TZ_CET, 5'd22, 5'd6, 5'd4);
    send(utc_stamp(2024, 1, 1, 0, 0, 0));
    send(utc_stamp(2099, 12, 31, 22, 59, 59));
    send(utc_stamp(2099, 12, 31, 23, 0, 0));
    send(utc_stamp(2024, 2, 28, 23, 30, 15));
    send(utc_stamp(2025, 2, 28, 23, 0, 0));
    send(utc_stamp(2024, 2, 29, 12, 0, 0));
    send(utc_stamp(2025, 2, 29, 12, 0, 0));
    send(utc_stamp(2024, 3, 31, 0, 59, 59));
    send(utc_stamp(2024, 3, 31, 1, 0, 0));
    send(utc_stamp(2024, 10, 27, 0, 59, 59));
    send(utc_stamp(2024, 10, 27, 1, 0, 0));
    send(utc_stamp(2024, 6, 30, 22, 0, 0));
    send(utc_stamp(2024, 12, 31, 23, 0, 0));
    send(utc_stamp(2023, 6, 15, 12, 0, 0));
    send(utc_stamp(2100, 1, 1, 0, 0, 0));
    send(utc_stamp(4095, 15, 31, 31, 63, 63));
    send(utc_stamp(0, 0, 0, 0, 0, 0));
    send(utc_stamp(2024, 13, 1, 0, 0, 0));
    send(utc_stamp(2024, 4, 31, 0, 0, 0));
    send(utc_stamp(2024, 5, 10, 24, 0, 0));
    send(utc_stamp(2024, 5, 10, 10, 60, 0));
    send(utc_stamp(2024, 5, 10, 10, 0, 60));
    send(utc_stamp(2024, 5, 10, 3, 59, 59));

    for (int s = 0; s < 8; s++) begin
      drain_results();
      program_registers(zone_set[s], start_set[s], end_set[s], turn_set[s]);
      send_pct = (s < 3) ? 7 : (s < 6) ? 73 : 0;
      recv_pct = (s < 3) ? 73 : (s < 6) ? 7 : 0;
      count = (zone_set[s] == TZ_NONE || zone_set[s] == TZ_BAD) ? 30 : 80;
      repeat (count) send(random_item());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
